// ===== hdl/assert_macros.svh =====
// assertion macros for the meter smoother blocks
// expects clk_i and rst_ni in the scope of use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define DCMS_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");
`define DCMS_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("forbidden condition");
`else
`define DCMS_ASSERT(label, prop)
`define DCMS_NEVER(label, cond)
`endif
`endif

// ===== hdl/dcms_pkg.sv =====
// shared types, widths and constants of the meter smoother
// no dependencies
`timescale 1ns / 1ps
package dcms_pkg;

  localparam int SAMPLE_BITS = 10;

  localparam int WEIGHT_W = 7;
  localparam int OFFSET_W = 4;
  localparam int LIMIT_W  = 6;
  localparam int VACC_W   = 26;
  localparam int CACC_W   = 23;
  localparam int ADDR_W   = 5;
  localparam int DATA_W   = 32;

  localparam int VOLT_SCALE = 35000;
  localparam int CUR_NUM    = 25600 / 1024;
  localparam int CUR_SHIFT  = 1;
  localparam int CUR_GAIN   = 450;

  localparam int VX_W   = SAMPLE_BITS + 16;
  localparam int CH_W   = SAMPLE_BITS + 4;
  localparam int CX_W   = CH_W + 9;
  localparam int VMAX_W = (VX_W > VACC_W) ? VX_W : VACC_W;
  localparam int DIVD_W = WEIGHT_W + VMAX_W;
  localparam int DIVR_W = WEIGHT_W + 1;
  localparam int CNT_W  = $clog2(DIVD_W);

  localparam logic [WEIGHT_W-1:0] RST_WEIGHT    = WEIGHT_W'(90);
  localparam logic [OFFSET_W-1:0] RST_OFFSET    = OFFSET_W'(3);
  localparam logic [OFFSET_W-1:0] RST_THRESHOLD = OFFSET_W'(4);
  localparam logic [LIMIT_W-1:0]  RST_VLIMIT    = LIMIT_W'(50);
  localparam logic [LIMIT_W-1:0]  RST_CLIMIT    = LIMIT_W'(5);

  typedef enum logic [2:0] {
    REG_WEIGHT    = 3'd0,
    REG_OFFSET    = 3'd1,
    REG_THRESHOLD = 3'd2,
    REG_VLIMIT    = 3'd3,
    REG_CLIMIT    = 3'd4
  } reg_idx_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCALE,
    ST_MAC,
    ST_DIV,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [WEIGHT_W-1:0] weight;
    logic [OFFSET_W-1:0] offset;
    logic [OFFSET_W-1:0] threshold;
    logic [LIMIT_W-1:0]  vlimit;
    logic [LIMIT_W-1:0]  climit;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic scale;
    logic mac;
    logic step;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/dual_channel_meter_smoother.sv =====
// top level of the dual channel meter smoother
// depends on dcms_pkg, dcms_regs, dcms_ctrl, dcms_datapath, assert_macros.svh
//
// channel  | direction | handshake              | payload
// input    | in        | in_valid_i/in_ready_o  | voltage_sample_i, current_sample_i
// output   | out       | out_valid_o/out_ready_i| levels and present flags
// config   | in        | apb psel/penable       | paddr, pwdata, prdata
//
// one item in flight at a time, the next is taken only after the commit; the
// bit-per-cycle dividers apply the weight plus one
// a finished result waits in the output register while the next item is taken
// reset is asynchronous, no clearing pass; the item stays in DONE until the
// output register is free
`timescale 1ns / 1ps
`include "assert_macros.svh"
module dual_channel_meter_smoother (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [dcms_pkg::SAMPLE_BITS-1:0] voltage_sample_i,
  input  logic [dcms_pkg::SAMPLE_BITS-1:0] current_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dcms_pkg::VACC_W-1:0]      voltage_level_o,
  output logic [dcms_pkg::CACC_W-1:0]      current_level_o,
  output logic                             voltage_present_o,
  output logic                             current_present_o,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [dcms_pkg::ADDR_W-1:0]      paddr,
  input  logic [dcms_pkg::DATA_W-1:0]      pwdata,
  output logic [dcms_pkg::DATA_W-1:0]      prdata,
  output logic                             pready
);

  dcms_pkg::cfg_t cfg;
  dcms_pkg::cmd_t cmd;
  dcms_pkg::sts_t sts;

  dcms_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  dcms_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .cmd_o      (cmd),
    .sts_i      (sts)
  );

  dcms_datapath u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .cfg_i             (cfg),
    .voltage_sample_i  (voltage_sample_i),
    .current_sample_i  (current_sample_i),
    .out_valid_o       (out_valid_o),
    .out_ready_i       (out_ready_i),
    .voltage_level_o   (voltage_level_o),
    .current_level_o   (current_level_o),
    .voltage_present_o (voltage_present_o),
    .current_present_o (current_present_o)
  );

  `DCMS_ASSERT(a_one_item_in_flight, (in_valid_i && in_ready_o) |=> !in_ready_o)
  `DCMS_NEVER(a_vlevel_gated, out_valid_o && !voltage_present_o && voltage_level_o != '0)
  `DCMS_NEVER(a_clevel_gated, out_valid_o && !current_present_o && current_level_o != '0)
  `DCMS_ASSERT(a_commit_needs_room, cmd.commit |-> sts.out_free)

endmodule

// ===== hdl/dcms_regs.sv =====
// configuration registers behind the apb-style port
// depends on dcms_pkg
`timescale 1ns / 1ps
module dcms_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [dcms_pkg::ADDR_W-1:0] paddr,
  input  logic [dcms_pkg::DATA_W-1:0] pwdata,
  output logic [dcms_pkg::DATA_W-1:0] prdata,
  output logic                        pready,
  output dcms_pkg::cfg_t              cfg_o
);

  dcms_pkg::cfg_t   cfg_q, cfg_d;
  dcms_pkg::reg_idx_e idx;
  logic             wr_en;

  assign idx    = dcms_pkg::reg_idx_e'(paddr[dcms_pkg::ADDR_W-1:2]);
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        dcms_pkg::REG_WEIGHT:    cfg_d.weight    = pwdata[dcms_pkg::WEIGHT_W-1:0];
        dcms_pkg::REG_OFFSET:    cfg_d.offset    = pwdata[dcms_pkg::OFFSET_W-1:0];
        dcms_pkg::REG_THRESHOLD: cfg_d.threshold = pwdata[dcms_pkg::OFFSET_W-1:0];
        dcms_pkg::REG_VLIMIT:    cfg_d.vlimit    = pwdata[dcms_pkg::LIMIT_W-1:0];
        dcms_pkg::REG_CLIMIT:    cfg_d.climit    = pwdata[dcms_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      dcms_pkg::REG_WEIGHT:    prdata = dcms_pkg::DATA_W'(cfg_q.weight);
      dcms_pkg::REG_OFFSET:    prdata = dcms_pkg::DATA_W'(cfg_q.offset);
      dcms_pkg::REG_THRESHOLD: prdata = dcms_pkg::DATA_W'(cfg_q.threshold);
      dcms_pkg::REG_VLIMIT:    prdata = dcms_pkg::DATA_W'(cfg_q.vlimit);
      dcms_pkg::REG_CLIMIT:    prdata = dcms_pkg::DATA_W'(cfg_q.climit);
      default:                 prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.weight    <= dcms_pkg::RST_WEIGHT;
      cfg_q.offset    <= dcms_pkg::RST_OFFSET;
      cfg_q.threshold <= dcms_pkg::RST_THRESHOLD;
      cfg_q.vlimit    <= dcms_pkg::RST_VLIMIT;
      cfg_q.climit    <= dcms_pkg::RST_CLIMIT;
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

// ===== hdl/dcms_div.sv =====
// restoring divider, one quotient bit per step
// depends on dcms_pkg
`timescale 1ns / 1ps
module dcms_div (
  input  logic                        clk_i,
  input  logic                        start_i,
  input  logic                        step_i,
  input  logic [dcms_pkg::DIVD_W-1:0] dividend_i,
  input  logic [dcms_pkg::DIVR_W-1:0] divisor_i,
  output logic [dcms_pkg::DIVD_W-1:0] quotient_o
);

  logic [dcms_pkg::DIVD_W-1:0] dq_q, dq_d;
  logic [dcms_pkg::DIVR_W-1:0] rem_q, rem_d;
  logic [dcms_pkg::DIVR_W-1:0] dvs_q, dvs_d;
  logic [dcms_pkg::DIVR_W:0]   shifted;
  logic [dcms_pkg::DIVR_W:0]   diff;
  logic                        ge;

  assign shifted    = {rem_q, dq_q[dcms_pkg::DIVD_W-1]};
  assign ge         = shifted >= {1'b0, dvs_q};
  assign diff       = shifted - {1'b0, dvs_q};
  assign quotient_o = dq_q;

  always_comb begin
    dq_d  = dq_q;
    rem_d = rem_q;
    dvs_d = dvs_q;
    if (start_i) begin
      dq_d  = dividend_i;
      rem_d = '0;
      dvs_d = divisor_i;
    end else if (step_i) begin
      dq_d  = {dq_q[dcms_pkg::DIVD_W-2:0], ge};
      rem_d = ge ? diff[dcms_pkg::DIVR_W-1:0] : shifted[dcms_pkg::DIVR_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    dq_q  <= dq_d;
    rem_q <= rem_d;
    dvs_q <= dvs_d;
  end

endmodule

// ===== hdl/dcms_datapath.sv =====
// scaling, weighted sums, dividers, presence counters and output register
// depends on dcms_pkg and dcms_div
`timescale 1ns / 1ps
module dcms_datapath (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  dcms_pkg::cmd_t                   cmd_i,
  output dcms_pkg::sts_t                   sts_o,
  input  dcms_pkg::cfg_t                   cfg_i,
  input  logic [dcms_pkg::SAMPLE_BITS-1:0] voltage_sample_i,
  input  logic [dcms_pkg::SAMPLE_BITS-1:0] current_sample_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [dcms_pkg::VACC_W-1:0]      voltage_level_o,
  output logic [dcms_pkg::CACC_W-1:0]      current_level_o,
  output logic                             voltage_present_o,
  output logic                             current_present_o
);

  localparam int SB = dcms_pkg::SAMPLE_BITS;
  localparam int DW = dcms_pkg::DIVD_W;
  localparam int LW = dcms_pkg::LIMIT_W;

  function automatic logic [LW-1:0] hold_next(input logic [LW-1:0] cnt,
                                              input logic pres,
                                              input logic [LW-1:0] limit);
    logic [LW-1:0] res;
    res = cnt;
    if (pres) begin
      if (cnt < limit) res = cnt + 1'b1;
    end else if (cnt != '0) begin
      res = cnt - 1'b1;
    end
    return res;
  endfunction

  logic [SB-1:0]                 vs_q, cs_q;
  logic [SB-1:0]                 cs_corr, off_ext, thr_ext;
  logic [dcms_pkg::CH_W:0]       ch_prod;
  logic [dcms_pkg::VX_W-1:0]     vx_q;
  logic [dcms_pkg::CH_W-1:0]     ch_q;
  logic                          vpres_q, cpres_q;
  logic [dcms_pkg::CX_W-1:0]     cx;
  logic [DW-1:0]                 vdvd, cdvd, vquo, cquo;
  logic [dcms_pkg::DIVR_W-1:0]   divisor;
  logic [dcms_pkg::VACC_W-1:0]   vacc_q, vacc_d;
  logic [dcms_pkg::CACC_W-1:0]   cacc_q, cacc_d;
  logic [LW-1:0]                 vcnt_q, vcnt_d, ccnt_q, ccnt_d;
  logic                          out_valid_q, out_valid_d;
  logic [dcms_pkg::VACC_W-1:0]   vlev_q;
  logic [dcms_pkg::CACC_W-1:0]   clev_q;
  logic                          vpr_q, cpr_q;

  assign off_ext = SB'(cfg_i.offset);
  assign thr_ext = SB'(cfg_i.threshold);
  assign cs_corr = (cs_q > off_ext) ? cs_q - off_ext : cs_q;
  assign ch_prod = (dcms_pkg::CH_W + 1)'(cs_corr) * (dcms_pkg::CH_W + 1)'(dcms_pkg::CUR_NUM);

  assign cx      = dcms_pkg::CX_W'(ch_q) * dcms_pkg::CX_W'(dcms_pkg::CUR_GAIN);
  assign vdvd    = DW'(cfg_i.weight) * DW'(vacc_q) + DW'(vx_q);
  assign cdvd    = DW'(cfg_i.weight) * DW'(cacc_q) + DW'(cx);
  assign divisor = dcms_pkg::DIVR_W'(cfg_i.weight) + 1'b1;

  dcms_div u_vdiv (
    .clk_i      (clk_i),
    .start_i    (cmd_i.mac),
    .step_i     (cmd_i.step),
    .dividend_i (vdvd),
    .divisor_i  (divisor),
    .quotient_o (vquo)
  );

  dcms_div u_cdiv (
    .clk_i      (clk_i),
    .start_i    (cmd_i.mac),
    .step_i     (cmd_i.step),
    .dividend_i (cdvd),
    .divisor_i  (divisor),
    .quotient_o (cquo)
  );

  // saturate at accumulator width
  assign vacc_d = (|vquo[DW-1:dcms_pkg::VACC_W]) ? '1 : vquo[dcms_pkg::VACC_W-1:0];
  assign cacc_d = (|cquo[DW-1:dcms_pkg::CACC_W]) ? '1 : cquo[dcms_pkg::CACC_W-1:0];
  assign vcnt_d = hold_next(vcnt_q, vpres_q, cfg_i.vlimit);
  assign ccnt_d = hold_next(ccnt_q, cpres_q, cfg_i.climit);

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  assign sts_o.out_free    = ~out_valid_q | out_ready_i;
  assign out_valid_o       = out_valid_q;
  assign voltage_level_o   = vlev_q;
  assign current_level_o   = clev_q;
  assign voltage_present_o = vpr_q;
  assign current_present_o = cpr_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      vs_q <= voltage_sample_i;
      cs_q <= current_sample_i;
    end
    if (cmd_i.scale) begin
      vx_q    <= dcms_pkg::VX_W'(vs_q) * dcms_pkg::VX_W'(dcms_pkg::VOLT_SCALE);
      ch_q    <= dcms_pkg::CH_W'(ch_prod >> dcms_pkg::CUR_SHIFT);
      vpres_q <= |vs_q;
      cpres_q <= cs_corr > thr_ext;
    end
    if (cmd_i.commit) begin
      vlev_q <= (vcnt_d != '0) ? vacc_d : '0;
      clev_q <= (ccnt_d != '0) ? cacc_d : '0;
      vpr_q  <= vcnt_d != '0;
      cpr_q  <= ccnt_d != '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vacc_q      <= '0;
      cacc_q      <= '0;
      vcnt_q      <= '0;
      ccnt_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
      if (cmd_i.commit) begin
        vacc_q <= vacc_d;
        cacc_q <= cacc_d;
        vcnt_q <= vcnt_d;
        ccnt_q <= ccnt_d;
      end
    end
  end

endmodule

// ===== hdl/dcms_ctrl.sv =====
// sequencing state machine: capture, scale, multiply-add, divide, commit
// depends on dcms_pkg
`timescale 1ns / 1ps
module dcms_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_ready_o,
  output dcms_pkg::cmd_t cmd_o,
  input  dcms_pkg::sts_t sts_i
);

  dcms_pkg::state_e            state_q, state_d;
  logic [dcms_pkg::CNT_W-1:0]  cnt_q, cnt_d;
  logic                        last_step;

  assign last_step = cnt_q == dcms_pkg::CNT_W'(dcms_pkg::DIVD_W - 1);

  always_comb begin
    state_d = state_q;
    case (state_q)
      dcms_pkg::ST_IDLE:  if (in_valid_i) state_d = dcms_pkg::ST_SCALE;
      dcms_pkg::ST_SCALE: state_d = dcms_pkg::ST_MAC;
      dcms_pkg::ST_MAC:   state_d = dcms_pkg::ST_DIV;
      dcms_pkg::ST_DIV:   if (last_step) state_d = dcms_pkg::ST_DONE;
      dcms_pkg::ST_DONE:  if (sts_i.out_free) state_d = dcms_pkg::ST_IDLE;
      default:            state_d = dcms_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cnt_d      = cnt_q;
    case (state_q)
      dcms_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      dcms_pkg::ST_SCALE: cmd_o.scale = 1'b1;
      dcms_pkg::ST_MAC: begin
        cmd_o.mac = 1'b1;
        cnt_d     = '0;
      end
      dcms_pkg::ST_DIV: begin
        cmd_o.step = 1'b1;
        cnt_d      = cnt_q + 1'b1;
      end
      dcms_pkg::ST_DONE:  cmd_o.commit = sts_i.out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= dcms_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule
